[src/lcdce_pkg.sv]
// ----------------------------------------------------------------------------
// lcdce_pkg: shared types and codes of the LCD command engine
// Field widths, operation codes, area codes and the transfer payloads.
// ----------------------------------------------------------------------------
package lcdce_pkg;

    localparam int FUNC_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int RAREA_W   = 2;
    localparam int INDEX_W   = 7;
    localparam int AREA_W    = 3;
    localparam int CURSOR_W  = 7;
    localparam int NUM_AREAS = 4;
    localparam int ADDR_A_W  = 5;

    // operation codes carried in func
    localparam logic [FUNC_W-1:0] FUNC_CMD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

    // RAM area codes
    localparam logic [AREA_W-1:0] AREA_DISP  = 3'd0;
    localparam logic [AREA_W-1:0] AREA_PICT  = 3'd1;
    localparam logic [AREA_W-1:0] AREA_GLYPH = 3'd2;
    localparam logic [AREA_W-1:0] AREA_LED   = 3'd3;
    localparam logic [AREA_W-1:0] AREA_NONE  = 3'd4;

    // command kinds in bits 7..6 of a command byte
    localparam logic [1:0] KIND_DATA_SET = 2'b01;
    localparam logic [1:0] KIND_ADDR_SET = 2'b10;

    // bytes per character in the character generator area
    localparam int GLYPH_STRIDE = 7;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [BYTE_W-1:0]  data_byte;
        logic [RAREA_W-1:0] read_area;
        logic [INDEX_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]    read_value;
        logic [NUM_AREAS-1:0] dirty_bits;
        logic [AREA_W-1:0]    selected_area;
        logic [CURSOR_W-1:0]  write_address;
    } t_out_item;

endpackage

[src/lcdce_in_if.sv]
// ----------------------------------------------------------------------------
// lcdce_in_if: input channel of the LCD command engine
// Valid/ready channel that carries one received byte and its operation.
// ----------------------------------------------------------------------------
interface lcdce_in_if;
    import lcdce_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

[src/lcdce_out_if.sv]
// ----------------------------------------------------------------------------
// lcdce_out_if: result channel of the LCD command engine
// Valid/ready channel that carries one result per accepted byte.
// ----------------------------------------------------------------------------
interface lcdce_out_if;
    import lcdce_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

[src/lcdce_store.sv]
// ----------------------------------------------------------------------------
// lcdce_store: unified area RAM with valid bits and write forwarding
// One read and one write port; a read colliding with a write returns the
// new byte. Entries never written read as zero.
// ----------------------------------------------------------------------------
module lcdce_store #(
    parameter int DEPTH = 146,
    parameter int AW    = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [lcdce_pkg::BYTE_W-1:0] i_wr_data,
    output logic [lcdce_pkg::BYTE_W-1:0] o_rd_data
);
    import lcdce_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [BYTE_W-1:0] r_q;
    logic              r_q_valid;
    logic              r_fwd_hit;
    logic [BYTE_W-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_valid <= r_valid[i_rd_addr];
                // take the byte being written in the same cycle
                r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : (r_q_valid ? r_q : '0);

endmodule

[src/lcd_controller_command_engine_unit.sv]
// ----------------------------------------------------------------------------
// lcd_controller_command_engine_unit: serial command engine of an LCD driver
// Pipeline: an accepted byte passes through the stage-one register and then
//   the output register, where its result is offered.
// Throughput: one byte per cycle while results are taken, set by the single
//   read port and the write-back from stage one, with forwarding between them.
// Reset: synchronous; clears area, cursor, mode, dirty flags and the RAM
//   valid bits together, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module lcd_controller_command_engine_unit #(
    parameter int DISPLAY_BYTES    = 25,
    parameter int PICTOGRAPH_BYTES = 8,
    parameter int GLYPH_BYTES      = 112,
    parameter int LED_BYTES        = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcdce_in_if.sink    i_in,
    lcdce_out_if.source o_out
);
    import lcdce_pkg::*;

    // All four areas share one RAM, laid out back to back.
    localparam int STORE_DEPTH = DISPLAY_BYTES + PICTOGRAPH_BYTES + GLYPH_BYTES + LED_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam logic [STORE_AW-1:0] BASE_DISP  = STORE_AW'(0);
    localparam logic [STORE_AW-1:0] BASE_PICT  = STORE_AW'(DISPLAY_BYTES);
    localparam logic [STORE_AW-1:0] BASE_GLYPH = STORE_AW'(DISPLAY_BYTES + PICTOGRAPH_BYTES);
    localparam logic [STORE_AW-1:0] BASE_LED   =
        STORE_AW'(DISPLAY_BYTES + PICTOGRAPH_BYTES + GLYPH_BYTES);

    localparam logic [CURSOR_W-1:0] SIZE_DISP  = CURSOR_W'(DISPLAY_BYTES);
    localparam logic [CURSOR_W-1:0] SIZE_PICT  = CURSOR_W'(PICTOGRAPH_BYTES);
    localparam logic [CURSOR_W-1:0] SIZE_GLYPH = CURSOR_W'(GLYPH_BYTES);
    localparam logic [CURSOR_W-1:0] SIZE_LED   = CURSOR_W'(LED_BYTES);

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [BYTE_W-1:0]   data_byte;
        logic                hit;       // RAM access lies inside the area
        logic [1:0]          area;      // area of a data write
        logic [STORE_AW-1:0] addr;
        logic [AREA_W-1:0]   target;    // state after the step
        logic [CURSOR_W-1:0] cursor;
    } t_s1;

    function automatic logic [CURSOR_W-1:0] size_of(input logic [AREA_W-1:0] area);
        logic [CURSOR_W-1:0] sz;
        case (area)
            AREA_DISP:  sz = SIZE_DISP;
            AREA_PICT:  sz = SIZE_PICT;
            AREA_GLYPH: sz = SIZE_GLYPH;
            AREA_LED:   sz = SIZE_LED;
            default:    sz = '0;
        endcase
        return sz;
    endfunction

    function automatic logic [STORE_AW-1:0] base_of(input logic [AREA_W-1:0] area);
        logic [STORE_AW-1:0] bs;
        case (area)
            AREA_PICT:  bs = BASE_PICT;
            AREA_GLYPH: bs = BASE_GLYPH;
            AREA_LED:   bs = BASE_LED;
            default:    bs = BASE_DISP;
        endcase
        return bs;
    endfunction

    // Drop a cursor that runs past the end of its area back to zero.
    function automatic logic [CURSOR_W-1:0] wrap(input logic [CURSOR_W-1:0] c,
                                                 input logic [AREA_W-1:0]   area);
        return (c >= size_of(area)) ? '0 : c;
    endfunction

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [AREA_W-1:0]    r_target,  n_target;
    logic [CURSOR_W-1:0]  r_cursor,  n_cursor;
    logic                 r_autoinc, n_autoinc;
    logic [NUM_AREAS-1:0] r_flags,   n_flags;

    logic      r_s1_valid;
    t_s1       r_s1, n_s1;
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic                accept;
    logic                s1_advance;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic                wr_en;
    logic [BYTE_W-1:0]   ram_data;

    // Stage one moves on whenever the output register is free or emptying.
    assign s1_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;
    assign accept     = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // Stage 0: decode the byte, advance the cursor, issue the RAM read
    // ------------------------------------------------------------------
    always_comb begin
        logic [2:0]          mode;
        logic [ADDR_A_W-1:0] a;
        logic [CURSOR_W-1:0] c;
        logic [AREA_W-1:0]   rarea;

        n_target  = r_target;
        n_cursor  = r_cursor;
        n_autoinc = r_autoinc;
        mode      = i_in.item.data_byte[2:0];
        a         = i_in.item.data_byte[ADDR_A_W-1:0];
        c         = r_cursor;
        rarea     = {1'b0, i_in.item.read_area};

        n_s1           = '0;
        n_s1.func      = i_in.item.func;
        n_s1.data_byte = i_in.item.data_byte;
        n_s1.area      = r_target[1:0];

        case (i_in.item.func)
            FUNC_CMD: begin
                case (i_in.item.data_byte[7:6])
                    KIND_DATA_SET: begin
                        if (mode[2]) begin
                            n_target = AREA_NONE;
                            c        = '0;
                        end else begin
                            n_target = {1'b0, mode[1:0]};
                        end
                        if (mode inside {3'd0, 3'd1}) begin
                            n_autoinc = ~i_in.item.data_byte[3];
                        end else begin
                            n_autoinc = 1'b1;
                            c         = '0;
                        end
                        n_cursor = wrap(c, n_target);
                    end
                    KIND_ADDR_SET: begin
                        if (r_target != AREA_NONE) begin
                            if (r_target == AREA_GLYPH) begin
                                // character number times seven; numbers of sixteen and above give zero
                                c = a[ADDR_A_W-1] ? '0 :
                                    (CURSOR_W'({a[ADDR_A_W-2:0], 3'b000})
                                     - CURSOR_W'(a[ADDR_A_W-2:0]));
                            end else begin
                                c = CURSOR_W'(a);
                            end
                            n_cursor = wrap(c, r_target);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            FUNC_DATA: begin
                if (r_target != AREA_NONE) begin
                    n_s1.hit  = r_cursor < size_of(r_target);
                    n_s1.addr = base_of(r_target) + STORE_AW'(r_cursor);
                    if (r_autoinc) begin
                        n_cursor = wrap(r_cursor + CURSOR_W'(1), r_target);
                    end
                end
            end
            FUNC_READ: begin
                n_s1.hit  = i_in.item.read_index < size_of(rarea);
                n_s1.addr = base_of(rarea) + STORE_AW'(i_in.item.read_index);
            end
            default: begin
            end
        endcase

        if (!n_s1.hit) begin
            n_s1.addr = '0;
        end
        n_s1.target = n_target;
        n_s1.cursor = n_cursor;
    end

    assign rd_en   = accept && n_s1.hit;
    assign rd_addr = n_s1.addr;

    // ------------------------------------------------------------------
    // Stage 1: compare with the stored byte, write back, build the result
    // ------------------------------------------------------------------
    always_comb begin
        logic changed;
        changed = (r_s1.func == FUNC_DATA) && r_s1.hit && (ram_data != r_s1.data_byte);
        wr_en   = s1_advance && changed;

        n_flags = r_flags;
        if (r_s1.func == FUNC_CLEAR) begin
            n_flags = '0;
        end else if (changed) begin
            n_flags = r_flags | (NUM_AREAS'(1) << r_s1.area);
        end

        n_out.read_value    = ((r_s1.func == FUNC_READ) && r_s1.hit) ? ram_data : '0;
        n_out.dirty_bits    = n_flags;
        n_out.selected_area = r_s1.target;
        n_out.write_address = r_s1.cursor;
    end

    lcdce_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (STORE_AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1.addr),
        .i_wr_data (r_s1.data_byte),
        .o_rd_data (ram_data)
    );

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= AREA_NONE;
            r_cursor    <= '0;
            r_autoinc   <= 1'b0;
            r_flags     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_target  <= n_target;
                r_cursor  <= n_cursor;
                r_autoinc <= n_autoinc;
            end
            if (s1_advance) begin
                r_flags <= n_flags;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_wr_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (s1_advance && r_s1.func == FUNC_DATA && r_s1.hit))
        else $error("RAM write outside a data byte leaving stage one");

    a_clear_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && r_s1.func == FUNC_CLEAR) |=> (r_flags == '0))
        else $error("dirty flags not cleared");

    a_cursor_in_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cursor == '0) || (r_cursor < size_of(r_target)))
        else $error("cursor beyond its area");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule

[sim/lcd_controller_command_engine_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_controller_command_engine_unit_tb: self-checking bench for the LCD
// command engine
// Drives command, data, read and clear bytes through the input channel.
// Random gaps fall on both channels. A shadow copy of the four RAM areas,
// the cursor and the dirty flags predicts every result, and each result is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lcd_controller_command_engine_unit_tb;
    import lcdce_pkg::*;

    localparam int DISP_LEN    = 25;
    localparam int PICT_LEN    = 8;
    localparam int GLYPH_LEN   = 112;
    localparam int LED_LEN     = 1;
    localparam int BYTE_TARGET = 1650;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 8;
    localparam int REPORT_MAX  = 10;

    // Shadow of the engine: RAM contents, cursor, mode and dirty flags,
    // plus the queue of results still owed by the block.
    class ram_shadow;
        logic [BYTE_W-1:0]    ram [NUM_AREAS][GLYPH_LEN];
        logic [AREA_W-1:0]    area;
        logic [CURSOR_W-1:0]  cursor;
        logic                 auto_inc;
        logic [NUM_AREAS-1:0] dirty;
        t_out_item            owed_results[$];
        int                   failures;
        int                   checked;
        int                   ram_changes;
        int                   reads;

        function new();
            area        = AREA_NONE;
            cursor      = '0;
            auto_inc    = 1'b0;
            dirty       = '0;
            failures    = 0;
            checked     = 0;
            ram_changes = 0;
            reads       = 0;
            foreach (ram[a, i]) ram[a][i] = '0;
        endfunction

        function int unsigned area_len(logic [AREA_W-1:0] a);
            case (a)
                AREA_DISP:  return DISP_LEN;
                AREA_PICT:  return PICT_LEN;
                AREA_GLYPH: return GLYPH_LEN;
                AREA_LED:   return LED_LEN;
                default:    return 0;
            endcase
        endfunction

        function void wrap_cursor();
            if (cursor >= area_len(area)) cursor = '0;
        endfunction

        // Byte currently stored under the cursor; lets the stimulus send
        // rewrites that must leave the dirty flags alone.
        function logic [BYTE_W-1:0] byte_at_cursor();
            if (area != AREA_NONE && cursor < area_len(area))
                return ram[area[1:0]][cursor];
            return BYTE_W'($urandom_range(255));
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Apply one transferred byte to the shadow and queue its result.
        // Returns 0 when the byte leaves the engine untouched.
        function bit note_byte(t_in_item it);
            t_out_item          res;
            logic [BYTE_W-1:0]  b;
            logic [2:0]         mode;
            logic [ADDR_A_W-1:0] a;
            bit                 live;
            res  = '0;
            b    = it.data_byte;
            live = 1'b1;
            case (it.func)
                FUNC_CMD: begin
                    if (b[7:6] == KIND_DATA_SET) begin
                        mode = b[2:0];
                        if (mode <= AREA_LED) begin
                            area = mode;
                        end else begin
                            area   = AREA_NONE;
                            cursor = '0;
                        end
                        // display and pictograph honour the no-increment bit
                        if (mode <= AREA_PICT) begin
                            auto_inc = ~b[3];
                        end else begin
                            auto_inc = 1'b1;
                            cursor   = '0;
                        end
                        wrap_cursor();
                    end else if (b[7:6] == KIND_ADDR_SET && area != AREA_NONE) begin
                        a = b[ADDR_A_W-1:0];
                        if (area == AREA_GLYPH)
                            cursor = (a < 16) ? CURSOR_W'(a * GLYPH_STRIDE) : '0;
                        else
                            cursor = CURSOR_W'(a);
                        wrap_cursor();
                    end else begin
                        live = 1'b0;
                    end
                end
                FUNC_DATA: begin
                    if (area == AREA_NONE) begin
                        live = 1'b0;
                    end else begin
                        if (cursor < area_len(area) && ram[area[1:0]][cursor] != b) begin
                            ram[area[1:0]][cursor] = b;
                            dirty[area[1:0]]       = 1'b1;
                            ram_changes++;
                        end
                        if (auto_inc) begin
                            cursor = cursor + 1'b1;
                            wrap_cursor();
                        end
                    end
                end
                FUNC_READ: begin
                    reads++;
                    if (it.read_index < area_len({1'b0, it.read_area}))
                        res.read_value = ram[it.read_area][it.read_index];
                end
                default: begin
                    dirty = '0;
                end
            endcase
            res.dirty_bits    = dirty;
            res.selected_area = area;
            res.write_address = cursor;
            owed_results.push_back(res);
            return live;
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            checked++;
            if (owed_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("[%0t] result %0d arrived with nothing owed: %p",
                             $realtime, checked, got);
                return;
            end
            exp = owed_results.pop_front();
            if (got.read_value !== exp.read_value || got.dirty_bits !== exp.dirty_bits ||
                got.selected_area !== exp.selected_area ||
                got.write_address !== exp.write_address) begin
                failures++;
                if (failures <= REPORT_MAX) begin
                    $display("[%0t] result %0d mismatch", $realtime, checked);
                    $display("    expected value=%02h dirty=%h area=%0d addr=%0d",
                             exp.read_value, exp.dirty_bits, exp.selected_area,
                             exp.write_address);
                    $display("    actual   value=%02h dirty=%h area=%0d addr=%0d",
                             got.read_value, got.dirty_bits, got.selected_area,
                             got.write_address);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lcdce_in_if  in_ch ();
    lcdce_out_if out_ch ();

    lcd_controller_command_engine_unit #(
        .DISPLAY_BYTES   (DISP_LEN),
        .PICTOGRAPH_BYTES(PICT_LEN),
        .GLYPH_BYTES     (GLYPH_LEN),
        .LED_BYTES       (LED_LEN)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    ram_shadow sb;
    bit        steady_run;     // both sides skip idling while set
    bit        long_hold_req;  // asks the receiver for one long hold-off
    int        bytes_live;     // transfers that actually touched the engine

    // Free-running clock, 12 ns period.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (steady_run) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Build an item; the read fields are random unless the caller sets them.
    function automatic t_in_item make_item(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b);
        t_in_item it;
        it.func       = f;
        it.data_byte  = b;
        it.read_area  = RAREA_W'($urandom_range(3));
        it.read_index = INDEX_W'($urandom_range(127));
        return it;
    endfunction

    function automatic t_in_item make_read(logic [RAREA_W-1:0] ra, logic [INDEX_W-1:0] ri);
        t_in_item it;
        it            = make_item(FUNC_READ, BYTE_W'($urandom_range(255)));
        it.read_area  = ra;
        it.read_index = ri;
        return it;
    endfunction

    // Offer one byte after a random gap and hold it until the engine takes
    // it. Valid stays high straight into the next byte when there is no gap.
    task automatic send_byte(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item  <= it;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        if (sb.note_byte(it)) bytes_live++;
    endtask

    task automatic send_random_read();
        logic [RAREA_W-1:0] ra;
        logic [INDEX_W-1:0] ri;
        ra = RAREA_W'($urandom_range(3));
        if ($urandom_range(99) < 75)
            ri = INDEX_W'($urandom_range(sb.area_len({1'b0, ra}) - 1));
        else
            ri = INDEX_W'($urandom_range(127));
        send_byte(make_read(ra, ri));
    endtask

    // One strobe frame: mostly a data setting, an optional address setting
    // and a run of data bytes, with reads and clears mixed in. The rest is
    // noise or frames opened by an ignored command kind.
    task automatic send_frame();
        int                  r;
        int                  run;
        int                  p;
        logic [2:0]          mode;
        logic [ADDR_A_W-1:0] a;
        logic [BYTE_W-1:0]   b;
        r = $urandom_range(99);
        if (r < 8) begin
            run = $urandom_range(6, 1);
            repeat (run) begin
                b = BYTE_W'($urandom_range(255));
                send_byte(make_item(FUNC_W'($urandom_range(3)), b));
            end
        end else if (r < 14) begin
            b = {($urandom_range(1) != 0) ? 2'b11 : 2'b00, 6'($urandom_range(63))};
            send_byte(make_item(FUNC_CMD, b));
            run = $urandom_range(4, 1);
            repeat (run) send_byte(make_item(FUNC_DATA, BYTE_W'($urandom_range(255))));
        end else begin
            if ($urandom_range(99) < 88)
                mode = 3'($urandom_range(AREA_LED));
            else
                mode = 3'($urandom_range(7, AREA_NONE));
            send_byte(make_item(FUNC_CMD, {KIND_DATA_SET, 3'($urandom_range(7)), mode}));
            if ($urandom_range(99) < 70) begin
                if (mode == AREA_GLYPH && $urandom_range(99) < 80)
                    a = ADDR_A_W'($urandom_range(15));
                else
                    a = ADDR_A_W'($urandom_range(31));
                send_byte(make_item(FUNC_CMD, {KIND_ADDR_SET, 1'($urandom_range(1)), a}));
            end
            run = (mode == AREA_GLYPH) ? $urandom_range(24, 1) : $urandom_range(12, 1);
            repeat (run) begin
                p = $urandom_range(99);
                if (p < 6)
                    send_random_read();
                else if (p < 9)
                    send_byte(make_item(FUNC_CLEAR, BYTE_W'($urandom_range(255))));
                else if (p < 30)
                    send_byte(make_item(FUNC_DATA, sb.byte_at_cursor()));
                else
                    send_byte(make_item(FUNC_DATA, BYTE_W'($urandom_range(255))));
            end
        end
    endtask

    // Result side: check every transfer, then decide ready for the next
    // cycle. The long hold-off is counted here so the sender can keep
    // pushing until the engine backs up.
    initial begin
        int stall;
        int hold_left;
        stall     = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_result(out_ch.item);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Watchdog: end the run once no transfer has happened on either channel
    // for far longer than any legal stall.
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("[%0t] watchdog: no transfer for %0d cycles, %0d results still owed",
                 $realtime, STALL_LIMIT, sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus: reset, directed bytes, then random frames.
    initial begin
        t_in_item opening[$];
        bit       held;
        bit       drained;
        sb            = new();
        held          = 1'b0;
        drained       = 1'b0;
        steady_run    = 1'b0;
        long_hold_req = 1'b0;
        bytes_live    = 0;
        i_rst_n       = 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.item   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // read out of range, data and address with no area selected
        opening.push_back(make_read(RAREA_W'(AREA_LED), 7'd127));
        opening.push_back(make_item(FUNC_DATA, 8'hAB));
        opening.push_back(make_item(FUNC_CMD, {KIND_ADDR_SET, 6'h1F}));
        // display, auto increment; rewrite of an equal byte keeps flags clear
        opening.push_back(make_item(FUNC_CMD, {KIND_DATA_SET, 3'b000, AREA_DISP}));
        opening.push_back(make_item(FUNC_DATA, 8'h00));
        opening.push_back(make_item(FUNC_CMD, {KIND_ADDR_SET, 6'd24}));
        opening.push_back(make_item(FUNC_DATA, 8'hFF));
        opening.push_back(make_item(FUNC_CMD, {KIND_ADDR_SET, 6'h1F}));
        // ignored command kinds: data still lands in the display
        opening.push_back(make_item(FUNC_CMD, 8'h0F));
        opening.push_back(make_item(FUNC_DATA, 8'h55));
        opening.push_back(make_item(FUNC_CMD, 8'hC1));
        // pictograph with the cursor held
        opening.push_back(make_item(FUNC_CMD, {KIND_DATA_SET, 3'b001, AREA_PICT}));
        opening.push_back(make_item(FUNC_DATA, 8'h12));
        opening.push_back(make_item(FUNC_DATA, 8'h34));
        // character generator: last character, then a number past the table
        opening.push_back(make_item(FUNC_CMD, {KIND_DATA_SET, 3'b111, AREA_GLYPH}));
        opening.push_back(make_item(FUNC_CMD, {KIND_ADDR_SET, 6'd15}));
        opening.push_back(make_item(FUNC_DATA, 8'h7E));
        opening.push_back(make_item(FUNC_CMD, {KIND_ADDR_SET, 6'd16}));
        // LED area wraps on every byte
        opening.push_back(make_item(FUNC_CMD, {KIND_DATA_SET, 3'b000, AREA_LED}));
        opening.push_back(make_item(FUNC_DATA, 8'h80));
        opening.push_back(make_item(FUNC_DATA, 8'h01));
        // modes with no area, then a stray data byte
        opening.push_back(make_item(FUNC_CMD, {KIND_DATA_SET, 3'b000, 3'd4}));
        opening.push_back(make_item(FUNC_CMD, {KIND_DATA_SET, 3'b001, 3'd7}));
        opening.push_back(make_item(FUNC_DATA, 8'h33));
        opening.push_back(make_read(RAREA_W'(AREA_GLYPH), 7'd105));
        opening.push_back(make_read(RAREA_W'(AREA_DISP), 7'd25));
        opening.push_back(make_item(FUNC_CLEAR, 8'h00));
        foreach (opening[i]) send_byte(opening[i]);

        while (bytes_live < BYTE_TARGET) begin
            if (!held && bytes_live >= 400) begin
                // hold the result side off and keep offering until input stalls
                held          = 1'b1;
                long_hold_req = 1'b1;
                steady_run    = 1'b1;
                repeat (3) send_frame();
            end
            if (!drained && bytes_live >= 1000) begin
                // withdraw the last byte so it is not taken twice while idle
                drained      = 1'b1;
                in_ch.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            steady_run = ($urandom_range(7) == 0);
            send_frame();
        end
        steady_run = 1'b0;
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("Covered %0d results, %0d effective bytes, %0d RAM changes, %0d reads,",
                 sb.checked, bytes_live, sb.ram_changes, sb.reads);
        $display("including a long result-side hold-off and a full drain mid-run.");
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d bad results, %0d still owed", sb.failures, sb.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
